/* src/frpt_pkg.sv */
// ----------------------------------------------------------------------------
// frpt_pkg: shared types and constants of the flood route parent tracker
// Item, result and configuration records, message and action codes, and
// the reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package frpt_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned HOP_W    = 8;
  localparam int unsigned JIT_W    = 9;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned WAIT_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Configuration register reset values
  localparam logic [HOP_W-1:0]  MAX_HOP_RST   = 8'd16;
  localparam logic [ADDR_W-1:0] NO_PARENT_RST = 16'hFFFF;
  localparam logic [WAIT_W-1:0] WAIT_TICKS_RST = 16'd1000;

  // Input item kinds
  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_FLOOD  = 2'd1,
    ACT_REPORT = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_HOP    = 2'd0,
    CFG_NO_PARENT  = 2'd1,
    CFG_WAIT_TICKS = 2'd2
  } cfg_idx_t;

  // Transmitted message kinds
  localparam logic MSG_FLOOD  = 1'b0;
  localparam logic MSG_REPORT = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] source;
    logic [SEQ_W-1:0]  seq_no;
    logic [HOP_W-1:0]  hops;
    logic [JIT_W-1:0]  jitter;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_addr;
    logic              msg_kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [HOP_W-1:0]  out_hops;
  } result_t;

  typedef struct packed {
    logic [HOP_W-1:0]  max_hop;
    logic [ADDR_W-1:0] no_parent_addr;
    logic [WAIT_W-1:0] parent_wait_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* src/frpt_in_if.sv */
// ----------------------------------------------------------------------------
// frpt_in_if: received message / tick channel
// Valid/ready channel carrying one received flood, report or tick per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface frpt_in_if;
  logic                         valid;
  logic                         ready;
  logic [frpt_pkg::ACT_W-1:0]   action;
  logic [frpt_pkg::ADDR_W-1:0]  source;
  logic [frpt_pkg::SEQ_W-1:0]   seq_no;
  logic [frpt_pkg::HOP_W-1:0]   hops;
  logic [frpt_pkg::JIT_W-1:0]   jitter;

  modport source_mp (output valid, action, source, seq_no, hops, jitter, input ready);
  modport sink_mp   (input valid, action, source, seq_no, hops, jitter, output ready);
endinterface

`default_nettype wire

/* src/frpt_out_if.sv */
// ----------------------------------------------------------------------------
// frpt_out_if: transmit request channel
// Valid/ready channel carrying one message to transmit per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface frpt_out_if;
  logic                         valid;
  logic                         ready;
  logic [frpt_pkg::ADDR_W-1:0]  dest_addr;
  logic                         msg_kind;
  logic [frpt_pkg::SEQ_W-1:0]   out_seq;
  logic [frpt_pkg::HOP_W-1:0]   out_hops;

  modport source_mp (output valid, dest_addr, msg_kind, out_seq, out_hops, input ready);
  modport sink_mp   (input valid, dest_addr, msg_kind, out_seq, out_hops, output ready);
endinterface

`default_nettype wire

/* src/frpt_cfg.sv */
// ----------------------------------------------------------------------------
// frpt_cfg: configuration register file
// Holds max hop count, broadcast / no-parent address and parent wait time.
// ----------------------------------------------------------------------------
`default_nettype none

module frpt_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            we,
  input  wire logic [frpt_pkg::CFG_IDX_W-1:0]  index,
  input  wire logic [frpt_pkg::CFG_DAT_W-1:0]  wdata,
  output frpt_pkg::cfg_t                       cfg
);

  frpt_pkg::cfg_t cfg_r;
  frpt_pkg::cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (index)
        frpt_pkg::CFG_MAX_HOP:    cfg_nxt.max_hop           = wdata[frpt_pkg::HOP_W-1:0];
        frpt_pkg::CFG_NO_PARENT:  cfg_nxt.no_parent_addr    = wdata[frpt_pkg::ADDR_W-1:0];
        frpt_pkg::CFG_WAIT_TICKS: cfg_nxt.parent_wait_ticks = wdata[frpt_pkg::WAIT_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_hop           <= frpt_pkg::MAX_HOP_RST;
      cfg_r.no_parent_addr    <= frpt_pkg::NO_PARENT_RST;
      cfg_r.parent_wait_ticks <= frpt_pkg::WAIT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/frpt_state.sv */
// ----------------------------------------------------------------------------
// frpt_state: routing state and timers
// Applies one registered item per cycle while go is high to the flood / parent / timer state
// and produces the transmit request that a tick fires, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module frpt_state (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire frpt_pkg::item_t  item,
  input  wire frpt_pkg::cfg_t   cfg,
  output logic                  res_vld,
  output frpt_pkg::result_t     res
);

  // Pending transmission, one-hot
  typedef enum logic [2:0] {
    SEND_NONE   = 3'b001,
    SEND_FLOOD  = 3'b010,
    SEND_REPORT = 3'b100
  } send_kind_t;

  logic [frpt_pkg::SEQ_W-1:0]  flood_seq_r,   flood_seq_nxt;
  logic [frpt_pkg::HOP_W-1:0]  own_hops_r,    own_hops_nxt;
  logic [frpt_pkg::HOP_W-1:0]  best_hops_r,   best_hops_nxt;
  logic [frpt_pkg::ADDR_W-1:0] parent_r,      parent_nxt;
  logic [frpt_pkg::ADDR_W-1:0] cand_parent_r, cand_parent_nxt;
  logic [frpt_pkg::HOP_W-1:0]  cand_hops_r,   cand_hops_nxt;
  logic [frpt_pkg::ADDR_W-1:0] rpt_dest_r,    rpt_dest_nxt;
  logic [frpt_pkg::SEQ_W-1:0]  rpt_seq_r,     rpt_seq_nxt;
  send_kind_t                  send_r,        send_nxt;
  logic [frpt_pkg::JIT_W-1:0]  send_cnt_r,    send_cnt_nxt;
  logic                        wait_r,        wait_nxt;
  logic [frpt_pkg::WAIT_W-1:0] wait_cnt_r,    wait_cnt_nxt;

  logic no_parent;
  assign no_parent = (parent_r == cfg.no_parent_addr);

  // Next state and fired result
  always_comb begin
    flood_seq_nxt   = flood_seq_r;
    own_hops_nxt    = own_hops_r;
    best_hops_nxt   = best_hops_r;
    parent_nxt      = parent_r;
    cand_parent_nxt = cand_parent_r;
    cand_hops_nxt   = cand_hops_r;
    rpt_dest_nxt    = rpt_dest_r;
    rpt_seq_nxt     = rpt_seq_r;
    send_nxt        = send_r;
    send_cnt_nxt    = send_cnt_r;
    wait_nxt        = wait_r;
    wait_cnt_nxt    = wait_cnt_r;
    res_vld         = 1'b0;
    res.dest_addr   = rpt_dest_r;
    res.msg_kind    = frpt_pkg::MSG_REPORT;
    res.out_seq     = rpt_seq_r;
    res.out_hops    = own_hops_r;
    if (send_r == SEND_FLOOD) begin
      res.dest_addr = cfg.no_parent_addr;
      res.msg_kind  = frpt_pkg::MSG_FLOOD;
      res.out_seq   = flood_seq_r;
    end

    if (go) begin
      unique case (item.action)
        frpt_pkg::ACT_TICK: begin
          // Wait timer: adopt the candidate when it runs out
          if (wait_r) begin
            if (wait_cnt_r <= frpt_pkg::WAIT_W'(1)) begin
              wait_nxt      = 1'b0;
              parent_nxt    = cand_parent_r;
              best_hops_nxt = cand_hops_r;
            end else begin
              wait_cnt_nxt = wait_cnt_r - frpt_pkg::WAIT_W'(1);
            end
          end
          // Send timer: fire or count down
          if (send_r != SEND_NONE) begin
            if (send_cnt_r <= frpt_pkg::JIT_W'(1)) begin
              res_vld      = 1'b1;
              send_nxt     = SEND_NONE;
              send_cnt_nxt = '0;
            end else begin
              send_cnt_nxt = send_cnt_r - frpt_pkg::JIT_W'(1);
            end
          end
        end
        frpt_pkg::ACT_FLOOD: begin
          if (item.seq_no > flood_seq_r) begin
            wait_nxt = 1'b0;
            if (item.hops < best_hops_r || no_parent) begin
              parent_nxt    = item.source;
              best_hops_nxt = item.hops;
            end else if (item.source != parent_r) begin
              cand_parent_nxt = item.source;
              cand_hops_nxt   = item.hops;
              wait_nxt        = 1'b1;
              wait_cnt_nxt    = cfg.parent_wait_ticks;
            end
            flood_seq_nxt = item.seq_no;
            if (item.hops < cfg.max_hop) begin
              own_hops_nxt = item.hops + frpt_pkg::HOP_W'(1);
              send_nxt     = SEND_FLOOD;
              send_cnt_nxt = item.jitter;
            end
          end else if (item.seq_no < flood_seq_r) begin
            // Stale flood: report back to the sender
            rpt_dest_nxt = item.source;
            rpt_seq_nxt  = flood_seq_r;
            own_hops_nxt = cfg.max_hop - item.hops;
            send_nxt     = SEND_REPORT;
            send_cnt_nxt = item.jitter;
          end
        end
        frpt_pkg::ACT_REPORT: begin
          // Forward a fresh report toward the parent
          if (item.hops < cfg.max_hop && item.seq_no > flood_seq_r &&
              item.source != cfg.no_parent_addr && !no_parent) begin
            rpt_dest_nxt = parent_r;
            rpt_seq_nxt  = item.seq_no;
            own_hops_nxt = item.hops + frpt_pkg::HOP_W'(1);
            send_nxt     = SEND_REPORT;
            send_cnt_nxt = item.jitter;
          end
        end
        default: begin
          // Unused code: drop the beat
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flood_seq_r <= '0;
      own_hops_r  <= frpt_pkg::MAX_HOP_RST;
      best_hops_r <= frpt_pkg::MAX_HOP_RST;
      parent_r    <= frpt_pkg::NO_PARENT_RST;
      send_r      <= SEND_NONE;
      send_cnt_r  <= '0;
      wait_r      <= 1'b0;
      wait_cnt_r  <= '0;
    end else begin
      flood_seq_r <= flood_seq_nxt;
      own_hops_r  <= own_hops_nxt;
      best_hops_r <= best_hops_nxt;
      parent_r    <= parent_nxt;
      send_r      <= send_nxt;
      send_cnt_r  <= send_cnt_nxt;
      wait_r      <= wait_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
    end
  end

  // Candidate and report payload
  always_ff @(posedge clk) begin
    cand_parent_r <= cand_parent_nxt;
    cand_hops_r   <= cand_hops_nxt;
    rpt_dest_r    <= rpt_dest_nxt;
    rpt_seq_r     <= rpt_seq_nxt;
  end

`ifndef SYNTHESIS
  // Results only come from an advancing tick
  a_res_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (go && item.action == frpt_pkg::ACT_TICK))
    else $error("result without a tick");

  // A fired send leaves nothing pending
  a_send_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (send_r == SEND_NONE))
    else $error("send still pending after firing");

  // A newer flood is adopted as the current sequence
  a_seq_adopt: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.action == frpt_pkg::ACT_FLOOD && item.seq_no > flood_seq_r)
      |=> (flood_seq_r == $past(item.seq_no)))
    else $error("newer flood sequence not adopted");
`endif

endmodule

`default_nettype wire

/* src/flood_route_parent_tracker.sv */
// A tick that fires a send reaches the output through the input register,
//   then the result register. Throughput: one item per cycle unless the
//   output stalls; the state update is a single registered pass.
// A stalled output holds one result; the input register can take one more item.
// Reset (rst_n, synchronous, active low) restores the configuration to its
//   defaults, clears the sequence and both timers and forgets the parent.
// ----------------------------------------------------------------------------
// flood_route_parent_tracker: flooding route builder, node side
// Tracks the newest flood sequence, the min-hop parent and a candidate
// parent, and issues rebroadcasts and reports after a jitter delay.
// ----------------------------------------------------------------------------
`default_nettype none

module flood_route_parent_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  frpt_in_if.sink_mp                           in_bus,
  frpt_out_if.source_mp                        out_bus,
  input  wire logic                            cfg_we,
  input  wire logic [frpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [frpt_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  frpt_pkg::cfg_t    cfg;
  frpt_pkg::item_t   item_r;
  logic              in_vld_r;
  logic              advance;
  logic              res_vld;
  frpt_pkg::result_t res;
  frpt_pkg::result_t out_r;
  logic              out_vld_r;
  logic              in_take;

  frpt_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // Process the held beat whenever the result register can take a result
  assign advance      = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !in_vld_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action <= in_bus.action;
      item_r.source <= in_bus.source;
      item_r.seq_no <= in_bus.seq_no;
      item_r.hops   <= in_bus.hops;
      item_r.jitter <= in_bus.jitter;
    end
  end

  frpt_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register: load a fired send, drop the beat once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_r <= res;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.dest_addr = out_r.dest_addr;
  assign out_bus.msg_kind  = out_r.msg_kind;
  assign out_bus.out_seq   = out_r.out_seq;
  assign out_bus.out_hops  = out_r.out_hops;

`ifndef SYNTHESIS
  // A held beat that cannot advance is kept
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> in_vld_r)
    else $error("input beat lost while stalled");

  // A fired result reaches the result register
  a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_vld) |=> out_vld_r)
    else $error("fired result not registered");
`endif

endmodule

`default_nettype wire
